/* sv/int_to_ascii_radix_defines.svh */
// ----------------------------------------------------------------------------
// int_to_ascii_radix_defines
// Assertion macros used by the int_to_ascii_radix RTL file.
// ----------------------------------------------------------------------------
`ifndef INT_TO_ASCII_RADIX_DEFINES_SVH
`define INT_TO_ASCII_RADIX_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising edge while out of reset.
`define I2A_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define I2A_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define I2A_ASSERT(label, clk, rstn, prop, msg)
`define I2A_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* sv/i2a_pkg.sv */
// ----------------------------------------------------------------------------
// i2a_pkg
// Types, codes and character helpers for the binary to ASCII radix converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int VALUE_W = 32;
    localparam int CMD_W   = 3;

    // Conversion kinds
    localparam logic [CMD_W-1:0] CMD_SDEC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UDEC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HEXL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HEXU = 3'd3;
    localparam logic [CMD_W-1:0] CMD_OCT  = 3'd4;

    // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for any x < 2^32
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_MINUS   = 7'h2D;
    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_OCT
    } radix_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIG,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic   load_mul;
        radix_t radix;
    } du_ctrl_t;

    function automatic logic [6:0] digit_ascii(input logic [3:0] digit, input logic upper);
        logic [6:0] d7;
        d7 = {3'b000, digit};
        if (digit < 4'd10) begin
            digit_ascii = ASCII_ZERO + d7;
        end else if (upper) begin
            digit_ascii = ASCII_UPPER_A + d7 - 7'd10;
        end else begin
            digit_ascii = ASCII_LOWER_A + d7 - 7'd10;
        end
    endfunction

endpackage

/* sv/i2a_digit_unit.sv */
// ----------------------------------------------------------------------------
// i2a_digit_unit
// Shared digit extractor: splits a magnitude into its lowest digit and the
// remaining quotient. Decimal goes through a registered reciprocal multiply;
// hex and octal are plain shift and mask.
// ----------------------------------------------------------------------------
module i2a_digit_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  i2a_pkg::du_ctrl_t     ctrl,
    input  logic [DATA_WIDTH-1:0] mag,
    output logic [3:0]            digit,
    output logic [DATA_WIDTH-1:0] quot
);

    localparam int PROD_W = DATA_WIDTH + 32;

    logic [PROD_W-1:0]     prod_reg;
    logic [DATA_WIDTH-1:0] quot_dec;
    logic [3:0]            tens4;

    // mag must stay put between the multiply and the remainder cycle
    always_ff @(posedge aclk) begin
        if (ctrl.load_mul) begin
            prod_reg <= PROD_W'(mag) * PROD_W'(i2a_pkg::DIV10_RECIP);
        end
    end

    assign quot_dec = DATA_WIDTH'(prod_reg >> i2a_pkg::DIV10_SHIFT);

    // low nibble of quot*10 is all the remainder needs
    assign tens4 = {quot_dec[0], 3'b000} + {quot_dec[2:0], 1'b0};

    always_comb begin
        case (ctrl.radix)
            i2a_pkg::RADIX_DEC: begin
                digit = mag[3:0] - tens4;
                quot  = quot_dec;
            end
            i2a_pkg::RADIX_HEX: begin
                digit = mag[3:0];
                quot  = mag >> 4;
            end
            i2a_pkg::RADIX_OCT: begin
                digit = {1'b0, mag[2:0]};
                quot  = mag >> 3;
            end
            default: begin
                digit = mag[3:0];
                quot  = mag >> 4;
            end
        endcase
    end

endmodule

/* sv/int_to_ascii_radix.sv */
// ----------------------------------------------------------------------------
// int_to_ascii_radix
// Converts a word to ASCII text in decimal (signed or unsigned), hex or octal,
// most significant character first, last character flagged with tlast.
// ----------------------------------------------------------------------------
// Sequence: the word is taken in idle, then each decimal digit gets a reciprocal
//   multiply step and then a remainder step, each hex/octal digit one digit step, then
//   characters go out; first character appears after all digits are formed.
// A new word is taken only once the last character of the previous one is loaded into
//   the output register; the single shared digit unit serves one word. Invalid kinds are dropped.
// Reset: synchronous; sequencer idle, output word empty. No clearing pass.
`include "int_to_ascii_radix_defines.svh"

module int_to_ascii_radix #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
    output logic        m_tlast
);

    localparam int MAX_DIGITS = (DATA_WIDTH + 2) / 3;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    i2a_pkg::state_t       state_reg, state_next;
    i2a_pkg::radix_t       radix_reg, radix_next;
    logic [DATA_WIDTH-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic                  upper_reg, upper_next;

    logic [3:0]            dig_mem [MAX_DIGITS];
    logic                  dig_we;
    logic [3:0]            dig_rd_reg;
    logic [CNT_W-1:0]      rd_addr;

    logic                  m_tvalid_reg;
    logic [6:0]            m_char_reg;
    logic                  m_tlast_reg;
    logic                  out_free;
    logic                  out_load;
    logic [6:0]            out_char;
    logic                  out_last;

    i2a_pkg::du_ctrl_t     du_ctrl;
    logic [3:0]            du_digit;
    logic [DATA_WIDTH-1:0] du_quot;

    logic [DATA_WIDTH-1:0] in_val;
    logic                  in_neg;
    logic [CNT_W-1:0]      rd_cnt;

    i2a_digit_unit #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_digit (
        .aclk  (aclk),
        .ctrl  (du_ctrl),
        .mag   (mag_reg),
        .digit (du_digit),
        .quot  (du_quot)
    );

    assign in_val   = s_tdata[DATA_WIDTH-1:0];
    assign in_neg   = (s_tuser == i2a_pkg::CMD_SDEC) && in_val[DATA_WIDTH-1];
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_cnt   = cnt_reg - CNT_W'(1);
    assign rd_addr  = cnt_next - CNT_W'(1);
    assign out_char = i2a_pkg::digit_ascii(dig_rd_reg, upper_reg);

    always_comb begin
        state_next = state_reg;
        radix_next = radix_reg;
        mag_next   = mag_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        upper_next = upper_reg;
        du_ctrl    = '{load_mul: 1'b0, radix: radix_reg};
        dig_we     = 1'b0;
        out_load   = 1'b0;
        out_last   = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            i2a_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                neg_next   = in_neg;
                upper_next = (s_tuser == i2a_pkg::CMD_HEXU);
                mag_next   = in_neg ? DATA_WIDTH'(~in_val + DATA_WIDTH'(1)) : in_val;
                cnt_next   = '0;
                if (s_tvalid) begin
                    case (s_tuser)
                        i2a_pkg::CMD_SDEC, i2a_pkg::CMD_UDEC: begin
                            radix_next = i2a_pkg::RADIX_DEC;
                            state_next = i2a_pkg::ST_MUL;
                        end
                        i2a_pkg::CMD_HEXL, i2a_pkg::CMD_HEXU: begin
                            radix_next = i2a_pkg::RADIX_HEX;
                            state_next = i2a_pkg::ST_DIG;
                        end
                        i2a_pkg::CMD_OCT: begin
                            radix_next = i2a_pkg::RADIX_OCT;
                            state_next = i2a_pkg::ST_DIG;
                        end
                        default: begin
                            state_next = i2a_pkg::ST_IDLE;   // unused kind: no output
                        end
                    endcase
                end
            end
            i2a_pkg::ST_MUL: begin
                du_ctrl.load_mul = 1'b1;
                state_next       = i2a_pkg::ST_DIG;
            end
            i2a_pkg::ST_DIG: begin
                dig_we   = 1'b1;
                mag_next = du_quot;
                cnt_next = cnt_reg + CNT_W'(1);
                if (du_quot == '0) begin
                    state_next = neg_reg ? i2a_pkg::ST_SIGN : i2a_pkg::ST_EMIT;
                end else if (radix_reg == i2a_pkg::RADIX_DEC) begin
                    state_next = i2a_pkg::ST_MUL;
                end
            end
            i2a_pkg::ST_SIGN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT: begin
                out_last = (cnt_reg == CNT_W'(1));
                if (out_free) begin
                    out_load = 1'b1;
                    cnt_next = rd_cnt;
                    if (out_last) begin
                        state_next = i2a_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2a_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        radix_reg <= radix_next;
        mag_reg   <= mag_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        upper_reg <= upper_next;
    end

    // digits are stored least significant first, read back from the top
    always_ff @(posedge aclk) begin
        if (dig_we) begin
            dig_mem[cnt_reg[IDX_W-1:0]] <= du_digit;
        end
        // while a digit is written, it is also the one to be read next
        dig_rd_reg <= dig_we ? du_digit : dig_mem[rd_addr[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_char_reg  <= (state_reg == i2a_pkg::ST_SIGN) ? i2a_pkg::ASCII_MINUS : out_char;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_tlast_reg;

    `I2A_ASSERT(a_dig_in_range, aclk, aresetn,
        (state_reg == i2a_pkg::ST_DIG) |-> (cnt_reg < CNT_W'(MAX_DIGITS)),
        "digit buffer overrun")
    `I2A_ASSERT(a_emit_nonempty, aclk, aresetn,
        (state_reg == i2a_pkg::ST_EMIT) |-> (cnt_reg != '0),
        "emit with no digits left")
    `I2A_ASSERT(a_bad_cmd_idle, aclk, aresetn,
        (s_tvalid && s_tready && s_tuser != i2a_pkg::CMD_SDEC
            && s_tuser != i2a_pkg::CMD_UDEC && s_tuser != i2a_pkg::CMD_HEXL
            && s_tuser != i2a_pkg::CMD_HEXU && s_tuser != i2a_pkg::CMD_OCT)
            |=> (state_reg == i2a_pkg::ST_IDLE),
        "unused kind started a conversion")
    `I2A_ASSERT(a_last_not_minus, aclk, aresetn,
        (m_tvalid && m_tlast) |-> (m_tdata[6:0] != i2a_pkg::ASCII_MINUS),
        "final word is a minus sign")
    `I2A_ASSERT(a_sign_only_neg, aclk, aresetn,
        (state_reg == i2a_pkg::ST_SIGN) |-> neg_reg,
        "sign emitted for non-negative value")

endmodule
